@@ rtl/icg_pkg.sv @@
// icg_pkg: types, register map and constants of the inversive congruential generator
// used by icg_cfg and the top level; no dependencies
`default_nettype none

package icg_pkg;

    localparam int ICG_WORD_W = 32;
    localparam int CFG_ADDR_W = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] CFG_IDX_MODULUS = 2'd0;
    localparam logic [1:0] CFG_IDX_MULT    = 2'd1;
    localparam logic [1:0] CFG_IDX_OFFSET  = 2'd2;

    localparam logic [ICG_WORD_W-1:0] MODULUS_RESET = 32'd2147483647;
    localparam logic [ICG_WORD_W-1:0] MULT_RESET    = 32'd1;
    localparam logic [ICG_WORD_W-1:0] OFFSET_RESET  = 32'd1;

    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [ICG_WORD_W-1:0] seed_value;
    } icg_in_t;

    typedef struct packed {
        logic [ICG_WORD_W-1:0] state_out;
        logic                  bad_offset;
    } icg_out_t;

    typedef struct packed {
        logic [ICG_WORD_W-1:0] modulus;
        logic [ICG_WORD_W-1:0] mult;
        logic [ICG_WORD_W-1:0] offset;
    } icg_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_C,
        ST_RED_X,
        ST_EUC_TEST,
        ST_EUC_DIV,
        ST_EUC_MUL,
        ST_INV,
        ST_FIN_MUL,
        ST_OUT
    } icg_state_t;

endpackage

`default_nettype wire

@@ rtl/inversive_congruential_generator.sv @@
// inversive_congruential_generator: top level, sequencer and state of the generator
// depends on icg_pkg, icg_cfg, icg_div, icg_mulmod
`default_nettype none

// Inversive congruential generator over modulus m (values below 2 act as 1). A step
// transaction (func 0) sets x to (a * inv(x) + c) mod m with inv(0) = 0 and inv = 0 where
// x has no inverse; a seed transaction (func 1) loads seed_value mod m. Each transaction
// returns the new state and bad_offset, set when c mod m is zero. One transaction is in
// work at a time; a finished result waits in the output register while the next
// transaction is taken. A seed runs three reductions mod m through the divider; a step runs
// the same reductions, then k remainder steps of the extended Euclid inverse, each a division
// and a modular product, and one final product (k is zero for a zero state and at most about
// 1.44*W, with W = 32 bit words). The divider and the modular multiplier are bit-serial, one of
// each, reused across the steps. Registers: modulus at 0x0, multiplier at 0x4, offset at
// 0x8; write only while no transaction is in flight.
module inversive_congruential_generator
    import icg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire icg_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output icg_out_t                   m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    localparam int W = ICG_WORD_W;

    icg_cfg_t     cfg;
    logic [W-1:0] m_eff;

    icg_state_t   state_reg, state_next;
    logic         func_reg, func_next;
    logic [W-1:0] seed_reg, seed_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] c_reg, c_next;
    logic [W-1:0] r0_reg, r0_next;
    logic [W-1:0] r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next;
    logic [W-1:0] t1_reg, t1_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] cur_reg, cur_next;
    icg_out_t     out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic         div_start;
    logic [W-1:0] div_num;
    logic [W-1:0] div_den;
    logic         div_done;
    logic [W-1:0] div_quot;
    logic [W-1:0] div_rem;

    logic         mul_start;
    logic [W-1:0] mul_mc;
    logic [W-1:0] mul_mpl;
    logic         mul_done;
    logic [W-1:0] mul_prod;

    logic [W-1:0] t_new;
    logic [W-1:0] inv_val;
    logic [W:0]   fin_sum;
    logic [W:0]   fin_red;
    logic         out_free;

    icg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    icg_div #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    icg_mulmod #(.W(W)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mc),
        .mplier  (mul_mpl),
        .modulus (m_eff),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign m_eff = (cfg.modulus < W'(2)) ? W'(1) : cfg.modulus;

    // t0 - q*t1 mod m, both terms below m
    assign t_new   = t0_reg - mul_prod + ((t0_reg >= mul_prod) ? '0 : m_eff);
    assign inv_val = (r0_reg == W'(1)) ? t0_reg : '0;
    assign fin_sum = {1'b0, mul_prod} + {1'b0, c_reg};
    assign fin_red = (fin_sum >= {1'b0, m_eff}) ? fin_sum - {1'b0, m_eff} : fin_sum;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        seed_next      = seed_reg;
        a_next         = a_reg;
        c_next         = c_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        res_next       = res_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        div_start      = 1'b0;
        div_num        = cfg.mult;
        div_den        = m_eff;
        mul_start      = 1'b0;
        mul_mc         = t1_reg;
        mul_mpl        = div_quot;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = s_data.func;
                    seed_next  = s_data.seed_value;
                    div_start  = 1'b1;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A: begin
                if (div_done) begin
                    a_next     = div_rem;
                    div_start  = 1'b1;
                    div_num    = cfg.offset;
                    state_next = ST_RED_C;
                end
            end
            ST_RED_C: begin
                if (div_done) begin
                    c_next     = div_rem;
                    div_start  = 1'b1;
                    div_num    = (func_reg == FUNC_SEED) ? seed_reg : cur_reg;
                    state_next = ST_RED_X;
                end
            end
            ST_RED_X: begin
                if (div_done) begin
                    if (func_reg == FUNC_SEED) begin
                        res_next   = div_rem;
                        state_next = ST_OUT;
                    end else if (div_rem == '0) begin
                        // zero state: no remainder steps, inverse comes out zero
                        r0_next    = '0;
                        r1_next    = '0;
                        t0_next    = '0;
                        t1_next    = '0;
                        state_next = ST_EUC_TEST;
                    end else begin
                        r0_next    = m_eff;
                        r1_next    = div_rem;
                        t0_next    = '0;
                        t1_next    = (m_eff == W'(1)) ? '0 : W'(1);
                        state_next = ST_EUC_TEST;
                    end
                end
            end
            ST_EUC_TEST: begin
                if (r1_reg == '0) begin
                    state_next = ST_INV;
                end else begin
                    div_start  = 1'b1;
                    div_num    = r0_reg;
                    div_den    = r1_reg;
                    state_next = ST_EUC_DIV;
                end
            end
            ST_EUC_DIV: begin
                if (div_done) begin
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    mul_start  = 1'b1;
                    mul_mc     = t1_reg;
                    mul_mpl    = div_quot;
                    state_next = ST_EUC_MUL;
                end
            end
            ST_EUC_MUL: begin
                if (mul_done) begin
                    t0_next    = t1_reg;
                    t1_next    = t_new;
                    state_next = ST_EUC_TEST;
                end
            end
            ST_INV: begin
                mul_start  = 1'b1;
                mul_mc     = a_reg;
                mul_mpl    = inv_val;
                state_next = ST_FIN_MUL;
            end
            ST_FIN_MUL: begin
                if (mul_done) begin
                    res_next   = fin_red[W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_next.state_out  = res_reg;
                    out_next.bad_offset = (c_reg == '0);
                    out_valid_next      = 1'b1;
                    cur_next            = res_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        seed_reg <= seed_next;
        a_reg    <= a_next;
        c_reg    <= c_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RED_A))
        else $error("accepted transaction did not start reduction");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_done && mul_done))
        else $error("divider and multiplier finished together");

    a_coef_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EUC_TEST) |-> ((t0_reg < m_eff) && (t1_reg < m_eff)))
        else $error("inverse coefficient not reduced");

    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.state_out < m_eff))
        else $error("result state not below modulus");
`endif

endmodule

`default_nettype wire

@@ rtl/icg_cfg.sv @@
// icg_cfg: APB-style register file holding modulus, multiplier and offset
// depends on icg_pkg
`default_nettype none

module icg_cfg
    import icg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output icg_cfg_t                   cfg
);

    icg_cfg_t   cfg_reg;
    icg_cfg_t   cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                CFG_IDX_MODULUS: cfg_next.modulus = pwdata;
                CFG_IDX_MULT:    cfg_next.mult    = pwdata;
                CFG_IDX_OFFSET:  cfg_next.offset  = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_IDX_MODULUS: prdata = cfg_reg.modulus;
            CFG_IDX_MULT:    prdata = cfg_reg.mult;
            CFG_IDX_OFFSET:  prdata = cfg_reg.offset;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus <= MODULUS_RESET;
            cfg_reg.mult    <= MULT_RESET;
            cfg_reg.offset  <= OFFSET_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/icg_div.sv @@
// icg_div: bit-serial restoring divider, one quotient bit per cycle
// gives quotient and remainder; no dependencies
`default_nettype none

module icg_div #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  num_reg;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    // dividend bits shift out at the top while quotient bits shift in at the bottom
    assign trial = {rem_reg, num_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            num_reg <= {num_reg[W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

@@ rtl/icg_mulmod.sv @@
// icg_mulmod: bit-serial modular multiplier, msb-first double-and-add with
// a doubling and a conditional add step per multiplier bit; no dependencies
`default_nettype none

module icg_mulmod #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] mcand,
    input  wire logic [W-1:0] mplier,
    input  wire logic [W-1:0] modulus,
    output logic              done,
    output logic      [W-1:0] product
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  mc_reg;
    logic [W-1:0]  mpl_reg;
    logic [CW-1:0] cnt_reg;
    logic          phase_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;

    // acc and mcand stay below the modulus, so one subtract reduces each step
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    assign sum     = {1'b0, acc_reg} + {1'b0, mc_reg};
    assign sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= CW'(W - 1);
            end else if (busy_reg) begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            mc_reg  <= mcand;
            mpl_reg <= mplier;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_reg <= dbl_red[W-1:0];
            end else begin
                if (mpl_reg[W-1]) begin
                    acc_reg <= sum_red[W-1:0];
                end
                mpl_reg <= {mpl_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire
